// ----- design/spb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite pixel blend package
// Shared widths, pixel mode and register index codes, colour constants and
// the structures that pass between the blocks of the sprite pixel blender.
// ----------------------------------------------------------------------------
package spb_pkg;

	localparam int PIXEL_W = 32;
	localparam int MODE_W  = 2;
	localparam int TRANSP_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Pixel mode codes. The spare code takes the 32-bit path.
	localparam logic [MODE_W-1:0] MODE_IDX8   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RGB565 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RGB888 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_ALPHA    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_ALPHA    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_TRANSP = 2'd3;

	// Colour constants.
	localparam logic [31:0] SPREAD_MASK_565 = 32'h07E0_F81F;
	localparam logic [31:0] RB_MASK         = 32'h00FF_00FF;
	localparam logic [31:0] G_MASK          = 32'h0000_FF00;
	localparam logic [31:0] ALPHA_OPAQUE    = 32'hFF00_0000;
	localparam logic [15:0] KEY_565         = 16'hF81F;
	localparam logic [23:0] KEY_888         = 24'hFF00FF;
	localparam logic [TRANSP_W-1:0] TRANSP_INVISIBLE = 8'hFF;

	typedef struct packed {
		logic [MODE_W-1:0]   pixel_mode;
		logic                source_has_alpha;
		logic                dest_has_alpha;
		logic [TRANSP_W-1:0] global_transparency;
	} cfg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] out_pixel;
		logic               write_enable;
	} res_t;

endpackage

// ----- design/spb_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite pixel blend stream interfaces
// Valid/ready channels for the source/destination pixel pair and for the
// blended result word.
// ----------------------------------------------------------------------------
interface spb_src_if import spb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] src_pixel;
	logic [PIXEL_W-1:0] dst_pixel;

	modport source (output valid, output src_pixel, output dst_pixel, input ready);
	modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface spb_res_if import spb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] out_pixel;
	logic               write_enable;

	modport source (output valid, output out_pixel, output write_enable, input ready);
	modport sink   (input valid, input out_pixel, input write_enable, output ready);
endinterface

// ----- design/spb_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite pixel blend configuration registers
// Holds pixel mode, alpha flags and global transparency, written through a
// plain indexed write port.
// ----------------------------------------------------------------------------
module spb_cfg_regs import spb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode          <= MODE_RGB888;
			cfg_q.source_has_alpha    <= 1'b0;
			cfg_q.dest_has_alpha      <= 1'b0;
			cfg_q.global_transparency <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PIXEL_MODE:    cfg_q.pixel_mode          <= wr_data[MODE_W-1:0];
				REG_SRC_ALPHA:     cfg_q.source_has_alpha    <= wr_data[0];
				REG_DST_ALPHA:     cfg_q.dest_has_alpha      <= wr_data[0];
				REG_GLOBAL_TRANSP: cfg_q.global_transparency <= wr_data[TRANSP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/spb_blend_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite pixel blend core
// Combinational pixel path: transparency skip, colour key, 565 packed blend,
// 888 blend over 256 and additive saturating alpha.
// ----------------------------------------------------------------------------
module spb_blend_core import spb_pkg::*; (
	input  cfg_t               cfg,
	input  logic [PIXEL_W-1:0] src_pixel,
	input  logic [PIXEL_W-1:0] dst_pixel,
	output res_t               res
);

	logic [15:0] s16;
	logic [15:0] d16;
	logic [4:0]  level565;
	logic [8:0]  t_plus1;
	logic [31:0] bs;
	logic [31:0] bd;
	logic [31:0] prod565;
	logic [31:0] bl;
	logic [15:0] res565;
	logic [8:0]  level888;
	logic [8:0]  a_plus1;
	logic [8:0]  alpha_sum;
	logic [7:0]  alpha_sat;
	logic [31:0] rb_prod;
	logic [31:0] g_prod;
	logic [31:0] rb_sum;
	logic [31:0] g_sum;
	logic [31:0] res888;

	assign s16     = src_pixel[15:0];
	assign d16     = dst_pixel[15:0];
	assign t_plus1 = {1'b0, cfg.global_transparency} + 9'd1;
	// Only meaningful below full transparency, where t+1 fits in eight bits.
	assign level565 = t_plus1[7:3];

	// Packed 565 blend: green spread into the upper half, red/blue below.
	assign bs      = {s16, s16} & SPREAD_MASK_565;
	assign bd      = {d16, d16} & SPREAD_MASK_565;
	assign prod565 = (bs - bd) * {27'd0, level565};
	assign bl      = ((prod565 >> 5) + bd) & SPREAD_MASK_565;
	assign res565  = bl[15:0] | bl[31:16];

	// Blend level for the 888 path: per-pixel alpha or global transparency.
	assign a_plus1 = {1'b0, src_pixel[31:24]} + 9'd1;
	always_comb begin
		if (cfg.source_has_alpha) begin
			level888 = (src_pixel[31:24] == 8'd0) ? 9'd0 : a_plus1;
		end else begin
			level888 = t_plus1;
		end
	end

	// 888 blend, modulo 2^32, alpha forced opaque.
	assign rb_prod = ((src_pixel & RB_MASK) - (dst_pixel & RB_MASK)) * {23'd0, level888};
	assign g_prod  = ((src_pixel & G_MASK) - (dst_pixel & G_MASK)) * {23'd0, level888};
	assign rb_sum  = (rb_prod >> 8) + (dst_pixel & RB_MASK);
	assign g_sum   = (g_prod >> 8) + (dst_pixel & G_MASK);
	assign res888  = (g_sum & G_MASK) | (rb_sum & RB_MASK) | ALPHA_OPAQUE;

	// Additive alpha, saturated at full opacity.
	assign alpha_sum = {1'b0, src_pixel[31:24]} + {1'b0, dst_pixel[31:24]};
	assign alpha_sat = alpha_sum[8] ? 8'hFF : alpha_sum[7:0];

	// Result selection by mode; a skipped pixel gives a zero word.
	always_comb begin
		res.out_pixel    = '0;
		res.write_enable = 1'b0;
		if (cfg.global_transparency == TRANSP_INVISIBLE) begin
			res.write_enable = 1'b0;
		end else if (cfg.pixel_mode == MODE_IDX8) begin
			if (src_pixel[7:0] != 8'd0) begin
				res.out_pixel    = {24'd0, src_pixel[7:0]};
				res.write_enable = 1'b1;
			end
		end else if (cfg.pixel_mode == MODE_RGB565) begin
			if (s16 != KEY_565) begin
				res.write_enable = 1'b1;
				if (cfg.global_transparency == '0) begin
					res.out_pixel = {16'd0, s16};
				end else begin
					res.out_pixel = {16'd0, res565};
				end
			end
		end else if (src_pixel[23:0] != KEY_888) begin
			res.write_enable = 1'b1;
			if (cfg.source_has_alpha && cfg.dest_has_alpha) begin
				res.out_pixel = {alpha_sat, src_pixel[23:0]};
			end else if (!cfg.source_has_alpha && cfg.global_transparency == '0) begin
				res.out_pixel = src_pixel | ALPHA_OPAQUE;
			end else begin
				res.out_pixel = res888;
			end
		end
	end

endmodule

// ----- design/sprite_pixel_blend_unit.sv -----
`timescale 1ns / 1ps
// An accepted pixel pair is held in the input register, and its result
// word in the result register. Throughput: one pixel pair per cycle;
// the blend sits between the input register and the result register,
// and a full stage stalls only when the result word is not taken.
// Reset: arst_n clears both stage valids and loads pixel mode 2 (32-bit),
// no alpha flags and transparency 0.
// ----------------------------------------------------------------------------
// Sprite pixel blend unit
// Top level: configuration registers, input register, blend core and
// result register with valid/ready handshakes.
// ----------------------------------------------------------------------------
module sprite_pixel_blend_unit import spb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	spb_src_if.sink               src_chan,
	spb_res_if.source             res_chan
);

	cfg_t               cfg;
	logic               v_s1;
	logic [PIXEL_W-1:0] src_s1;
	logic [PIXEL_W-1:0] dst_s1;
	logic               v_s2;
	res_t               res_s2;
	res_t               core_res;
	logic               adv_s2;
	logic               adv_s1;

	spb_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result register can load when empty or when its word is taken.
	assign adv_s2 = !v_s2 || res_chan.ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign src_chan.ready = adv_s1;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= src_chan.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (adv_s1 && src_chan.valid) begin
			src_s1 <= src_chan.src_pixel;
			dst_s1 <= src_chan.dst_pixel;
		end
	end

	spb_blend_core u_core (
		.cfg       (cfg),
		.src_pixel (src_s1),
		.dst_pixel (dst_s1),
		.res       (core_res)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= core_res;
		end
	end

	assign res_chan.valid        = v_s2;
	assign res_chan.out_pixel    = res_s2.out_pixel;
	assign res_chan.write_enable = res_s2.write_enable;

endmodule

// ----- design/spb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite pixel blend checker
// Port-level assertions on the blend unit's handshakes and results, bound to
// the top level.
// ----------------------------------------------------------------------------
module spb_checker import spb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_wr_en,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [PIXEL_W-1:0]    out_pixel,
	input logic                  write_enable
);

	logic [TRANSP_W-1:0] transp_q;

	// Shadow of the global transparency register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transp_q <= '0;
		end else if (cfg_wr_en && cfg_index == REG_GLOBAL_TRANSP) begin
			transp_q <= cfg_data[TRANSP_W-1:0];
		end
	end

	// A waiting result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// With no result pending the unit always takes a new pixel pair.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output");

	// A fresh result word traces back to an accepted pair, via the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without an accepted pair");

	// A skipped pixel carries a zero word.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> out_pixel == '0)
		else $error("non-zero word on a skipped pixel");

	// Full transparency never writes.
	a_invisible: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transp_q == TRANSP_INVISIBLE |-> !write_enable)
		else $error("write at full transparency");

endmodule

bind sprite_pixel_blend_unit spb_checker u_spb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_wr_en    (cfg_wr_en),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.in_valid     (src_chan.valid),
	.in_ready     (src_chan.ready),
	.out_valid    (res_chan.valid),
	.out_ready    (res_chan.ready),
	.out_pixel    (res_chan.out_pixel),
	.write_enable (res_chan.write_enable)
);
